// ----- rtl/core/ult_pkg.sv -----
// ----------------------------------------------------------------------------
// ult_pkg: shared types and constants of the undirected link table
// Node count, field widths, result status codes and the control/status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ult_pkg;

  localparam int NODES  = 16;
  localparam int NODE_W = 4;                    // node fields are four bits
  localparam int LIM_W  = 5;                    // node_limit register width
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_LINKS  = 2'd2;

  localparam logic ACT_JOIN    = 1'b0;
  localparam logic ACT_DISJOIN = 1'b1;

  typedef logic [NODES-1:0] row_t;

  // controller -> datapath
  typedef struct packed {
    logic              load_item;
    logic              do_join;
    logic              start_scan;
    logic              clear_link;
    logic              step;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
    logic              emit_last;
  } ult_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic is_join;
    logic row_empty;
    logic bit_hit;
    logic last_hit;
    logic out_free;
  } ult_stat_t;

endpackage

// ----- rtl/core/ult_ctrl.sv -----
// ----------------------------------------------------------------------------
// ult_ctrl: sequencer of the undirected link table
// Takes one item at a time, decides join / reject / scan and steps the disjoin
// scan one node index per cycle (a hit waits for room), issuing result writes.
// ----------------------------------------------------------------------------
module ult_ctrl
  import ult_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ult_stat_t stat,
  output ult_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.out_free) begin
          if (stat.bad) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_BAD_INDEX;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else if (stat.is_join) begin
            cmd.do_join     = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_OK;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else if (stat.row_empty) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NO_LINKS;
            cmd.emit_last   = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.start_scan = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stat.bit_hit) begin
          cmd.step = 1'b1;
        end else if (stat.out_free) begin
          cmd.clear_link  = 1'b1;
          cmd.step        = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = stat.last_hit;
          if (stat.last_hit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/ult_dp.sv -----
// ----------------------------------------------------------------------------
// ult_dp: datapath of the undirected link table
// Link matrix in flops, item and scan registers, node_limit register and
// the result register that decouples the output handshake.
// ----------------------------------------------------------------------------
module ult_dp
  import ult_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ult_cmd_t          cmd,
  output ult_stat_t         stat,
  input  logic              in_action,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LIM_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [NODE_W-1:0] out_neighbor,
  output logic              out_last
);

  row_t              link_r [NODES];
  row_t              link_nxt [NODES];
  logic              act_r;
  logic [NODE_W-1:0] a_r, b_r, idx_r;
  row_t              scan_r;
  logic [LIM_W-1:0]  node_limit_r;
  logic [LIM_W-1:0]  lim, lim_m1;
  row_t              lim_mask, row_a, rest;
  logic              out_valid_r, out_last_r;
  logic [STAT_W-1:0] out_status_r;
  logic [NODE_W-1:0] out_neighbor_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_limit_r <= LIM_W'(NODES);
    end else if (cfg_valid) begin
      node_limit_r <= cfg_data;
    end
  end

  assign lim    = (node_limit_r > LIM_W'(NODES)) ? LIM_W'(NODES) : node_limit_r;
  assign lim_m1 = lim - LIM_W'(1);

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      lim_mask[i] = (LIM_W'(i) < lim);
    end
  end

  assign row_a = link_r[a_r] & lim_mask;
  // bits still pending below the current one
  assign rest  = scan_r & ~(row_t'(1) << idx_r);

  always_comb begin
    stat.bad       = ({1'b0, a_r} >= lim) || ((act_r == ACT_JOIN) && ({1'b0, b_r} >= lim));
    stat.is_join   = (act_r == ACT_JOIN);
    stat.row_empty = (row_a == '0);
    stat.bit_hit   = scan_r[idx_r];
    stat.last_hit  = (rest == '0);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_JOIN;
      a_r   <= '0;
      b_r   <= '0;
    end else if (cmd.load_item) begin
      act_r <= in_action;
      a_r   <= in_node_a;
      b_r   <= in_node_b;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      scan_r <= row_a;
      idx_r  <= lim_m1[NODE_W-1:0];
    end else begin
      if (cmd.clear_link) begin
        scan_r <= rest;
      end
      if (cmd.step) begin
        idx_r <= idx_r - NODE_W'(1);
      end
    end
  end

  // both directions of a link change together
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      link_nxt[i] = link_r[i];
      if (cmd.do_join) begin
        if (NODE_W'(i) == a_r) link_nxt[i] = link_nxt[i] | (row_t'(1) << b_r);
        if (NODE_W'(i) == b_r) link_nxt[i] = link_nxt[i] | (row_t'(1) << a_r);
      end
      if (cmd.clear_link) begin
        if (NODE_W'(i) == a_r)   link_nxt[i] = link_nxt[i] & ~(row_t'(1) << idx_r);
        if (NODE_W'(i) == idx_r) link_nxt[i] = link_nxt[i] & ~(row_t'(1) << a_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NODES; i++) begin
      if (!rst_n) begin
        link_r[i] <= '0;
      end else begin
        link_r[i] <= link_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r   <= cmd.emit_status;
      out_neighbor_r <= cmd.clear_link ? idx_r : '0;
      out_last_r     <= cmd.emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_neighbor = out_neighbor_r;
  assign out_last     = out_last_r;

`ifndef ASSERT_OFF
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result written over a pending item");

  a_clear_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_link |-> scan_r[idx_r])
    else $error("link cleared at a scan index without a link");

  a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    link_r[a_r][b_r] == link_r[b_r][a_r])
    else $error("link matrix lost symmetry");

  a_scan_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear_link && cmd.emit_last) |=> (scan_r == '0))
    else $error("scan ended with links left in the row");
`endif

endmodule

// ----- rtl/core/undirected_link_table.sv -----
// ----------------------------------------------------------------------------
// undirected_link_table: symmetric link matrix with join and disjoin items
// Join sets both directions of a link; disjoin removes every link of a node
// and reports each neighbor, highest index first.
// ----------------------------------------------------------------------------
// Join, bad_index and no_links: the item is registered, decided in S_DECODE once
// the result register is free, and the result is registered; a new item is taken
// only after that. Disjoin: the item is registered and decoded, then S_SCAN
// checks one node index per cycle from the highest usable index down while no
// hit waits on the output, clearing and reporting each link until the last one.
// Output stalls hold the scan. Synchronous reset clears all links and sets
// node_limit to 16.
// ----------------------------------------------------------------------------
module undirected_link_table
  import ult_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LIM_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [NODE_W-1:0] out_neighbor,
  output logic              out_last
);

  ult_cmd_t  cmd;
  ult_stat_t stat;

  ult_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ult_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_action),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_neighbor (out_neighbor),
    .out_last     (out_last)
  );

endmodule
